>>> rtl/vtp_pkg.sv
`default_nettype none
package vtp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  // three shifted products plus translation, with two growth bits
  localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
  localparam int SIZE_W    = 13;
  localparam int HALF_W    = SIZE_W - 1;
  localparam int NUM_W     = SUM_W + HALF_W + 1;
  localparam int REM_W     = NUM_W - 1;
  // quotient bits kept; anything at or above 2**Q_W saturates the screen
  localparam int Q_W       = 17;
  localparam int DIV_STEPS = Q_W + 1;
  localparam int CMP_W     = SUM_W + Q_W + 1;
  localparam int DEPTH_W   = 32;
  localparam int SCR_W     = 16;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam int DEPTH_SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DEPTH_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [PROD_W-1:0] DEPTH_FAR  = PROD_W'(64'd1000000 << FRAC_BITS);
  localparam logic [PROD_W-1:0] DEPTH_ONES = PROD_W'({DEPTH_W{1'b1}});

  typedef enum logic [2:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [REM_W-1:0]   rem_x;
    logic [REM_W-1:0]   rem_y;
    logic [Q_W-1:0]     q_x;
    logic [Q_W-1:0]     q_y;
    logic               ovf_x;
    logic               ovf_y;
    logic               neg_x;
    logic               neg_y;
    logic [SUM_W-1:0]   tz;
    logic               vis;
    logic [DEPTH_W-1:0] depth;
  } div_t;

endpackage
`default_nettype wire

>>> rtl/vtp_if.sv
`default_nettype none
interface vtp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vtp_pkg::COORD_W-1:0]   vertex_x;
  logic signed [vtp_pkg::COORD_W-1:0]   vertex_y;
  logic signed [vtp_pkg::COORD_W-1:0]   vertex_z;
  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface vtp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 visible;
  logic signed [vtp_pkg::SCR_W-1:0]     screen_x;
  logic signed [vtp_pkg::SCR_W-1:0]     screen_y;
  logic [vtp_pkg::DEPTH_W-1:0]          depth;
  modport source (output valid, visible, screen_x, screen_y, depth, input ready);
  modport sink (input valid, visible, screen_x, screen_y, depth, output ready);
endinterface
`default_nettype wire

>>> rtl/vertex_transform_project.sv
// vertex transform and perspective projection
// in_vtx_i carries one vertex per beat (x, y, z signed Q16.16); out_vtx_o
// carries one result per beat: visible flag, screen x/y and depth
// apb port holds the 3x4 matrix rows and the screen size, 64-bit registers
// at byte address 8*index; write only while the pipeline is empty
// latency: 23 cycles from an accepted input beat to its output beat
// throughput: one vertex per cycle; stage 0 holds nine 32x32 multipliers,
// stage 1 the row sums, stage 2 the scale by half size and the depth,
// stage 3 the magnitudes, then 18 restoring divide stages (one quotient
// bit each, the first only flags a saturating quotient), then the output
// register that adds the screen centre and saturates
// each stage has its own valid bit and moves whenever the next stage is
// empty or moving, so bubbles close up and new beats are taken while a
// finished result waits; a stall on out_vtx_o never drops or repeats a beat
// reset empties the pipeline and loads the identity-like default matrix
// and a 320x200 screen
`default_nettype none
module vertex_transform_project (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  vtp_in_if.sink                            in_vtx_i,
  vtp_out_if.source                         out_vtx_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vtp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [vtp_pkg::DATA_W-1:0]   pwdata,
  output logic      [vtp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int SW = vtp_pkg::SUM_W;

  // configuration registers
  logic [vtp_pkg::DATA_W-1:0] coef_q [6];
  logic [vtp_pkg::SIZE_W-1:0] width_q, height_q;
  vtp_pkg::reg_idx_e          cfg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = vtp_pkg::reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 64'h1_0000_0000;
      coef_q[1] <= '0;
      coef_q[2] <= 64'h1_0000;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
      coef_q[5] <= 64'h1_0000_0000;
      width_q   <= vtp_pkg::SIZE_W'(320);
      height_q  <= vtp_pkg::SIZE_W'(200);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vtp_pkg::REG_ROW0_A: coef_q[0] <= pwdata;
        vtp_pkg::REG_ROW0_B: coef_q[1] <= pwdata;
        vtp_pkg::REG_ROW1_A: coef_q[2] <= pwdata;
        vtp_pkg::REG_ROW1_B: coef_q[3] <= pwdata;
        vtp_pkg::REG_ROW2_A: coef_q[4] <= pwdata;
        vtp_pkg::REG_ROW2_B: coef_q[5] <= pwdata;
        vtp_pkg::REG_WIDTH:  width_q   <= pwdata[vtp_pkg::SIZE_W-1:0];
        vtp_pkg::REG_HEIGHT: height_q  <= pwdata[vtp_pkg::SIZE_W-1:0];
        default:             coef_q[0] <= coef_q[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vtp_pkg::REG_ROW0_A: prdata = coef_q[0];
      vtp_pkg::REG_ROW0_B: prdata = coef_q[1];
      vtp_pkg::REG_ROW1_A: prdata = coef_q[2];
      vtp_pkg::REG_ROW1_B: prdata = coef_q[3];
      vtp_pkg::REG_ROW2_A: prdata = coef_q[4];
      vtp_pkg::REG_ROW2_B: prdata = coef_q[5];
      vtp_pkg::REG_WIDTH:  prdata = vtp_pkg::DATA_W'(width_q);
      vtp_pkg::REG_HEIGHT: prdata = vtp_pkg::DATA_W'(height_q);
      default:             prdata = '0;
    endcase
  end

  logic [vtp_pkg::HALF_W-1:0] half_w, half_h;
  assign half_w = width_q[vtp_pkg::SIZE_W-1:1];
  assign half_h = height_q[vtp_pkg::SIZE_W-1:1];

  // valid bits and stage enables
  logic v0_q, v1_q, v2_q, vo_q;
  logic dv_q [vtp_pkg::DIV_STEPS+1];
  logic en0, en1, en2, en_out;
  logic en_div [vtp_pkg::DIV_STEPS+1];

  assign en_out = ~vo_q | out_vtx_o.ready;
  always_comb begin
    en_div[vtp_pkg::DIV_STEPS] = ~dv_q[vtp_pkg::DIV_STEPS] | en_out;
    for (int k = vtp_pkg::DIV_STEPS - 1; k >= 0; k--) begin
      en_div[k] = ~dv_q[k] | en_div[k+1];
    end
  end
  assign en2 = ~v2_q | en_div[0];
  assign en1 = ~v1_q | en2;
  assign en0 = ~v0_q | en1;
  assign in_vtx_i.ready = en0;

  // stage 0: nine products, row r column c at index 3*r+c
  logic signed [vtp_pkg::PROD_W-1:0] prod_d [9];
  logic signed [vtp_pkg::PROD_W-1:0] prod_q [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[3*r]   = $signed(coef_q[2*r][63:32]) * in_vtx_i.vertex_x;
      prod_d[3*r+1] = $signed(coef_q[2*r][31:0])  * in_vtx_i.vertex_y;
      prod_d[3*r+2] = $signed(coef_q[2*r+1][63:32]) * in_vtx_i.vertex_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) prod_q <= prod_d;
  end

  // stage 1: floor-shifted products plus translation
  logic signed [SW-1:0] t_d [3];
  logic signed [SW-1:0] t_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t_d[r] = SW'(prod_q[3*r]   >>> vtp_pkg::FRAC_BITS)
             + SW'(prod_q[3*r+1] >>> vtp_pkg::FRAC_BITS)
             + SW'(prod_q[3*r+2] >>> vtp_pkg::FRAC_BITS)
             + SW'($signed(coef_q[2*r+1][31:0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) t_q <= t_d;
  end

  // stage 2: numerators, visibility, depth
  logic signed [vtp_pkg::NUM_W-1:0]  numx_d, numy_d, numx_q, numy_q;
  logic [vtp_pkg::PROD_W-1:0]        tz_wide, depth_wide;
  logic [vtp_pkg::DEPTH_W-1:0]       depth_d, depth2_q;
  logic                              vis_d, vis2_q;
  logic [SW-1:0]                     tz2_q;

  always_comb begin
    numx_d     = t_q[0] * $signed({1'b0, half_w});
    numy_d     = t_q[1] * $signed({1'b0, half_h});
    vis_d      = (t_q[2] > 0);
    tz_wide    = vtp_pkg::PROD_W'(t_q[2]);
    depth_wide = (tz_wide >> vtp_pkg::DEPTH_SHR) << vtp_pkg::DEPTH_SHL;
    if (tz_wide > vtp_pkg::DEPTH_FAR || depth_wide > vtp_pkg::DEPTH_ONES) begin
      depth_d = '1;
    end else begin
      depth_d = depth_wide[vtp_pkg::DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      numx_q   <= numx_d;
      numy_q   <= numy_d;
      tz2_q    <= t_q[2];
      vis2_q   <= vis_d;
      depth2_q <= depth_d;
    end
  end

  // stage 3 (div_q[0]): magnitudes; div_q[1]: overflow flags; div_q[2..]: one quotient bit each
  vtp_pkg::div_t div_q [vtp_pkg::DIV_STEPS+1];
  vtp_pkg::div_t div_d [vtp_pkg::DIV_STEPS+1];

  always_comb begin
    div_d[0]       = '0;
    div_d[0].neg_x = numx_q[vtp_pkg::NUM_W-1];
    div_d[0].neg_y = numy_q[vtp_pkg::NUM_W-1];
    div_d[0].rem_x = vtp_pkg::REM_W'(numx_q[vtp_pkg::NUM_W-1] ? -numx_q : numx_q);
    div_d[0].rem_y = vtp_pkg::REM_W'(numy_q[vtp_pkg::NUM_W-1] ? -numy_q : numy_q);
    div_d[0].tz    = tz2_q;
    div_d[0].vis   = vis2_q;
    div_d[0].depth = depth2_q;
  end

  for (genvar k = 1; k <= vtp_pkg::DIV_STEPS; k++) begin : g_div
    localparam int SH = vtp_pkg::DIV_STEPS - k;
    logic [vtp_pkg::CMP_W-1:0] dvs;
    logic                      ge_x, ge_y;
    assign dvs  = vtp_pkg::CMP_W'(div_q[k-1].tz) << SH;
    assign ge_x = vtp_pkg::CMP_W'(div_q[k-1].rem_x) >= dvs;
    assign ge_y = vtp_pkg::CMP_W'(div_q[k-1].rem_y) >= dvs;
    always_comb begin
      div_d[k] = div_q[k-1];
      if (k == 1) begin
        // quotient of 2**Q_W or more saturates the screen coordinate
        div_d[k].ovf_x = ge_x;
        div_d[k].ovf_y = ge_y;
      end else begin
        if (ge_x) begin
          div_d[k].rem_x = div_q[k-1].rem_x - vtp_pkg::REM_W'(dvs);
          div_d[k].q_x   = div_q[k-1].q_x | vtp_pkg::Q_W'(1 << SH);
        end
        if (ge_y) begin
          div_d[k].rem_y = div_q[k-1].rem_y - vtp_pkg::REM_W'(dvs);
          div_d[k].q_y   = div_q[k-1].q_y | vtp_pkg::Q_W'(1 << SH);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= vtp_pkg::DIV_STEPS; k++) begin
      if (en_div[k]) div_q[k] <= div_d[k];
    end
  end

  // output stage: centre offset and saturation
  vtp_pkg::div_t            fin;
  logic signed [19:0]       qx_s, qy_s, sx_full, sy_full;
  logic signed [vtp_pkg::SCR_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic [vtp_pkg::DEPTH_W-1:0] depth_q;
  logic                     vis_q;

  function automatic logic signed [vtp_pkg::SCR_W-1:0] sat16(logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else return v[vtp_pkg::SCR_W-1:0];
  endfunction

  always_comb begin
    fin     = div_q[vtp_pkg::DIV_STEPS];
    qx_s    = fin.neg_x ? -$signed(20'(fin.q_x)) : $signed(20'(fin.q_x));
    qy_s    = fin.neg_y ? -$signed(20'(fin.q_y)) : $signed(20'(fin.q_y));
    sx_full = $signed(20'(half_w)) + qx_s;
    sy_full = $signed(20'(half_h)) - qy_s;
    if (!fin.vis) begin
      sx_d = '1;
    end else if (fin.ovf_x) begin
      sx_d = fin.neg_x ? 16'sh8000 : 16'sh7fff;
    end else begin
      sx_d = sat16(sx_full);
    end
    if (!fin.vis) begin
      sy_d = '1;
    end else if (fin.ovf_y) begin
      sy_d = fin.neg_y ? 16'sh7fff : 16'sh8000;
    end else begin
      sy_d = sat16(sy_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      vis_q   <= fin.vis;
      depth_q <= fin.vis ? fin.depth : '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= vtp_pkg::DIV_STEPS; k++) dv_q[k] <= 1'b0;
    end else begin
      if (en0) v0_q <= in_vtx_i.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en_div[0]) dv_q[0] <= v2_q;
      for (int k = 1; k <= vtp_pkg::DIV_STEPS; k++) begin
        if (en_div[k]) dv_q[k] <= dv_q[k-1];
      end
      if (en_out) vo_q <= dv_q[vtp_pkg::DIV_STEPS];
    end
  end

  assign out_vtx_o.valid    = vo_q;
  assign out_vtx_o.visible  = vis_q;
  assign out_vtx_o.screen_x = sx_q;
  assign out_vtx_o.screen_y = sy_q;
  assign out_vtx_o.depth    = depth_q;

endmodule
`default_nettype wire

>>> rtl/vtp_checker.sv
`default_nettype none
module vtp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          visible,
  input wire logic [vtp_pkg::SCR_W-1:0]     screen_x,
  input wire logic [vtp_pkg::SCR_W-1:0]     screen_y,
  input wire logic [vtp_pkg::DEPTH_W-1:0]   depth,
  input wire logic                          pready
);

  // hidden vertices carry the fixed marker pattern
  a_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !visible |-> screen_x == '1 && screen_y == '1 && depth == '1)
    else $error("hidden vertex payload wrong");

  // a visible vertex has a positive depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && visible |-> depth != '0)
    else $error("visible vertex with zero depth");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
      && $stable(depth) && $stable(visible))
    else $error("stalled output beat changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_vtx_o.valid),
  .out_ready (out_vtx_o.ready),
  .visible   (out_vtx_o.visible),
  .screen_x  (out_vtx_o.screen_x),
  .screen_y  (out_vtx_o.screen_y),
  .depth     (out_vtx_o.depth),
  .pready    (pready)
);
`default_nettype wire

>>> test/vertex_transform_project_tb.sv
`timescale 1ns / 1ps
module vertex_transform_project_tb;

  // one projected vertex as seen on the output channel
  typedef struct packed {
    logic                        visible;
    logic [vtp_pkg::SCR_W-1:0]   screen_x;
    logic [vtp_pkg::SCR_W-1:0]   screen_y;
    logic [vtp_pkg::DEPTH_W-1:0] depth;
  } screen_pt_t;

  // predictor plus store of pending projections
  class projection_board;
    logic [63:0]  coef_regs [vtp_pkg::NUM_REGS];
    screen_pt_t   pending [$];
    int           errors;

    function new();
      errors = 0;
      coef_regs[vtp_pkg::REG_ROW0_A] = 64'h1_0000_0000;
      coef_regs[vtp_pkg::REG_ROW0_B] = 64'h0;
      coef_regs[vtp_pkg::REG_ROW1_A] = 64'h1_0000;
      coef_regs[vtp_pkg::REG_ROW1_B] = 64'h0;
      coef_regs[vtp_pkg::REG_ROW2_A] = 64'h0;
      coef_regs[vtp_pkg::REG_ROW2_B] = 64'h1_0000_0000;
      coef_regs[vtp_pkg::REG_WIDTH]  = 64'd320;
      coef_regs[vtp_pkg::REG_HEIGHT] = 64'd200;
    endfunction

    function void set_reg(vtp_pkg::reg_idx_e idx, logic [63:0] val);
      if (idx == vtp_pkg::REG_WIDTH || idx == vtp_pkg::REG_HEIGHT) val = val & 64'h1FFF;
      coef_regs[idx] = val;
    endfunction

    // one matrix row: floored products, then the translation
    function longint row_sum(int r, longint x, longint y, longint z);
      logic [63:0] a, b;
      longint acc;
      a = coef_regs[2*r];
      b = coef_regs[2*r+1];
      acc = (longint'($signed(a[63:32])) * x) >>> vtp_pkg::FRAC_BITS;
      acc += (longint'($signed(a[31:0])) * y) >>> vtp_pkg::FRAC_BITS;
      acc += (longint'($signed(b[63:32])) * z) >>> vtp_pkg::FRAC_BITS;
      acc += longint'($signed(b[31:0]));
      return acc;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      longint x, y, z, tx, ty, tz, hw, hh, d;
      screen_pt_t p;
      x = longint'($signed(vx));
      y = longint'($signed(vy));
      z = longint'($signed(vz));
      tx = row_sum(0, x, y, z);
      ty = row_sum(1, x, y, z);
      tz = row_sum(2, x, y, z);
      if (tz <= 0) begin
        p = '{1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
      end else begin
        hw = longint'(coef_regs[vtp_pkg::REG_WIDTH]) / 2;
        hh = longint'(coef_regs[vtp_pkg::REG_HEIGHT]) / 2;
        p.visible  = 1'b1;
        p.screen_x = 16'(clamp16(hw + (tx * hw) / tz));
        p.screen_y = 16'(clamp16(hh - (ty * hh) / tz));
        if (tz > (longint'(1000000) << vtp_pkg::FRAC_BITS)) begin
          p.depth = '1;
        end else begin
          d = (tz >>> vtp_pkg::DEPTH_SHR) <<< vtp_pkg::DEPTH_SHL;
          p.depth = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
        end
      end
      pending.push_back(p);
    endfunction

    function void check_point(screen_pt_t got);
      screen_pt_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.visible !== want.visible) begin
        $display("%0t: visible exp %0b got %0b", $time, want.visible, got.visible);
        errors++;
      end
      if (got.screen_x !== want.screen_x) begin
        $display("%0t: screen_x exp %0d got %0d", $time,
                 $signed(want.screen_x), $signed(got.screen_x));
        errors++;
      end
      if (got.screen_y !== want.screen_y) begin
        $display("%0t: screen_y exp %0d got %0d", $time,
                 $signed(want.screen_y), $signed(got.screen_y));
        errors++;
      end
      if (got.depth !== want.depth) begin
        $display("%0t: depth exp %h got %h", $time, want.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 23;
  localparam int STALL_LIMIT = 2000;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [vtp_pkg::ADDR_W-1:0] paddr;
  logic [vtp_pkg::DATA_W-1:0] pwdata, prdata;

  vtp_in_if  vin ();
  vtp_out_if vout ();

  vertex_transform_project dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vtx_i  (vin.sink),
    .out_vtx_o (vout.source),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  projection_board board = new();
  int idle_cycles;
  bit stall_mode;   // receiver pattern selector

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vin.valid && vin.ready) begin
        board.note_vertex(vin.vertex_x, vin.vertex_y, vin.vertex_z);
      end
      if (vout.valid && vout.ready) begin
        board.check_point({vout.visible, vout.screen_x, vout.screen_y, vout.depth});
      end
      if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("vertex_transform_project_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern: sometimes always ready, sometimes bursty backpressure
  int ready_phase;
  always @(negedge clk_i) begin
    ready_phase <= ready_phase + 1;
    if (!stall_mode) vout.ready <= 1'b1;
    else if (ready_phase % 64 < 20) vout.ready <= (ready_phase % 3 != 0);
    else vout.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic apb_write(vtp_pkg::reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= vtp_pkg::ADDR_W'(idx * 8); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, val);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for all pending projections plus pipeline depth
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // drive one beat at the falling edge, hold until accepted
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vin.valid <= 1'b1;
    vin.vertex_x <= x; vin.vertex_y <= y; vin.vertex_z <= z;
    @(posedge clk_i);
    while (!vin.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    vin.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($urandom_range(1, 400) << 16);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return 32'h10000;
    endcase
  endfunction

  // random burst phase with well-formed scenes mostly in front of the camera
  task automatic random_phase(int count);
    int burst;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && n < count; i++) begin
        if ($urandom_range(0, 9) < 7)
          send_vertex(rand_coord(1), rand_coord(1), rand_coord(2));
        else
          send_vertex(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                      rand_coord($urandom_range(0, 3)));
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(1);
  endtask

  task automatic random_matrix();
    int k;
    k = $urandom_range(0, 2);
    apb_write(vtp_pkg::REG_ROW0_A, {rand_coef(k), rand_coef(k)});
    apb_write(vtp_pkg::REG_ROW0_B, {rand_coef(k), rand_coef(0)});
    apb_write(vtp_pkg::REG_ROW1_A, {rand_coef(k), rand_coef(k)});
    apb_write(vtp_pkg::REG_ROW1_B, {rand_coef(k), rand_coef(0)});
    apb_write(vtp_pkg::REG_ROW2_A, {rand_coef(1), rand_coef(1)});
    apb_write(vtp_pkg::REG_ROW2_B, {rand_coef(2), 32'($urandom_range(0, 1 << 20))});
    apb_write(vtp_pkg::REG_WIDTH, 64'($urandom_range(0, 8191)));
    apb_write(vtp_pkg::REG_HEIGHT, 64'($urandom_range(0, 8191)));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    vin.valid = 1'b0; vin.vertex_x = '0; vin.vertex_y = '0; vin.vertex_z = '0;
    vout.ready = 1'b0;
    ready_phase = 0; stall_mode = 1'b0; idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed beats at reset settings: extremes, behind camera
    send_vertex(32'h0, 32'h0, 32'h0001_0000);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h0, 32'h0, 32'hFFFF_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_vertex(32'h0005_0000, 32'hFFFB_0000, 32'h000A_0000);
    send_vertex(32'h0, 32'h0, 32'h7FFF_FFFF);
    idle_gap(1);
    drain();

    // large translation on z gives depth near the top of its range
    apb_write(vtp_pkg::REG_ROW2_B, {32'h0001_0000, 32'h7FFF_FFFF});
    apb_write(vtp_pkg::REG_WIDTH, 64'd0);
    apb_write(vtp_pkg::REG_HEIGHT, 64'd1);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    send_vertex(32'h0, 32'h0, 32'h0);
    idle_gap(1);
    drain();

    // extreme coefficients and the largest screen height
    apb_write(vtp_pkg::REG_ROW0_A, 64'h7FFF_FFFF_8000_0000);
    apb_write(vtp_pkg::REG_ROW0_B, 64'h8000_0000_7FFF_FFFF);
    apb_write(vtp_pkg::REG_ROW1_A, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(vtp_pkg::REG_ROW1_B, 64'h7FFF_FFFF_8000_0000);
    apb_write(vtp_pkg::REG_ROW2_A, 64'h0);
    apb_write(vtp_pkg::REG_ROW2_B, 64'h0000_0001_0000_0001);
    apb_write(vtp_pkg::REG_WIDTH, 64'd4096);
    apb_write(vtp_pkg::REG_HEIGHT, 64'd8191);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0010);
    idle_gap(1);
    drain();

    // random phases under changing matrices and backpressure
    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph[0];
      random_matrix();
      random_phase(125);
      drain();
    end

    idle_gap(1);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("vertex_transform_project_tb: PASS");
    end else begin
      $display("vertex_transform_project_tb: FAIL");
    end
    $finish;
  end

endmodule
